// ===== hdl/mtes_pkg.sv =====
// Shared types and constants for the MIDI track event serializer.
`default_nettype none
package mtes_pkg;

	localparam int unsigned VLQ_W       = 28;
	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic       REQ_EVENT        = 1'b0;
	localparam logic       REQ_END_OF_TRACK = 1'b1;

	localparam logic [3:0] KIND_LOWEST_VALID = 4'h8;
	localparam logic [3:0] KIND_PROGRAM      = 4'hC;
	localparam logic [3:0] KIND_PRESSURE     = 4'hD;
	localparam logic [3:0] KIND_SYSTEM       = 4'hF;

	localparam logic [7:0] META_PREFIX  = 8'hFF;
	localparam logic [7:0] META_EOT     = 8'h2F;
	localparam logic [7:0] META_EOT_LEN = 8'h00;

	typedef struct packed {
		logic        req_type;
		logic [31:0] event_tick;
		logic [3:0]  message_kind;
		logic [4:0]  channel;
		logic [7:0]  data_first;
		logic [7:0]  data_second;
		logic [27:0] end_delta;
	} req_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        last;
		logic [31:0] track_bytes;
	} rsp_t;

	typedef struct packed {
		logic             eot;
		logic [VLQ_W-1:0] vlq;
		logic [2:0]       vlq_len;
		logic             send_status;
		logic [7:0]       status;
		logic [6:0]       data_first;
		logic [6:0]       data_second;
		logic             two_data;
	} desc_t;

endpackage
`default_nettype wire

// ===== hdl/mtes_queue.sv =====
// Small FIFO between the classifying front end and the byte serializer.
`default_nettype none
module mtes_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  not_full,
	input  wire logic             pop,
	output logic                  not_empty,
	output logic [WIDTH-1:0]      head_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign not_full  = (count_q != CNT_FULL);
	assign not_empty = (count_q != '0);
	assign head_data = mem_q[rd_ptr_q];
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/mtes_front.sv =====
// Front end: accept requests, track running status and last tick, build byte plans.
`default_nettype none
module mtes_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire mtes_pkg::req_t req,
	input  wire logic          queue_ready,
	output logic               push,
	output mtes_pkg::desc_t    desc
);
	import mtes_pkg::*;

	logic [31:0]      prev_tick_q;
	logic [7:0]       run_status_q;
	logic             accept;
	logic             is_eot;
	logic             kind_ok;
	logic [31:0]      delta;
	logic [VLQ_W-1:0] vlq;
	logic [3:0]       chan_nib;
	logic [4:0]       chan_m1;
	logic [7:0]       status;

	assign req_ready = queue_ready;
	assign accept    = req_valid && queue_ready;
	assign is_eot    = (req.req_type == REQ_END_OF_TRACK);
	assign kind_ok   = (req.message_kind >= KIND_LOWEST_VALID) &&
	                   (req.message_kind != KIND_SYSTEM);
	assign delta     = req.event_tick - prev_tick_q;
	assign chan_m1   = req.channel - 5'd1;
	assign chan_nib  = (req.channel != 5'd0) ? chan_m1[3:0] : 4'd0;
	assign status    = {req.message_kind, chan_nib};
	assign vlq       = is_eot ? req.end_delta : delta[VLQ_W-1:0];
	assign push      = accept && (is_eot || kind_ok);

	always_comb begin
		desc             = '0;
		desc.eot         = is_eot;
		desc.vlq         = vlq;
		desc.status      = status;
		desc.send_status = !is_eot && (status != run_status_q);
		desc.data_first  = req.data_first[6:0];
		desc.data_second = req.data_second[6:0];
		desc.two_data    = (req.message_kind != KIND_PROGRAM) &&
		                   (req.message_kind != KIND_PRESSURE);
		if (vlq[27:21] != '0) begin
			desc.vlq_len = 3'd4;
		end else if (vlq[20:14] != '0) begin
			desc.vlq_len = 3'd3;
		end else if (vlq[13:7] != '0) begin
			desc.vlq_len = 3'd2;
		end else begin
			desc.vlq_len = 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_tick_q  <= '0;
			run_status_q <= '0;
		end else if (accept) begin
			if (is_eot) begin
				prev_tick_q  <= '0;
				run_status_q <= '0;
			end else if (kind_ok) begin
				prev_tick_q  <= req.event_tick;
				run_status_q <= status;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/mtes_back.sv =====
// Back end: walk each byte plan one byte per beat and keep the track byte count.
`default_nettype none
module mtes_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           head_valid,
	input  wire mtes_pkg::desc_t head,
	output logic                pop,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output mtes_pkg::rsp_t      rsp
);
	import mtes_pkg::*;

	function automatic logic [7:0] byte_at(input desc_t d, input logic [2:0] idx);
		logic [2:0] gi;
		logic [2:0] ti;
		logic [6:0] grp;
		logic [7:0] b;
		gi = d.vlq_len - 3'd1 - idx;
		ti = idx - d.vlq_len;
		b  = '0;
		if (idx < d.vlq_len) begin
			case (gi[1:0])
				2'd0:    grp = d.vlq[6:0];
				2'd1:    grp = d.vlq[13:7];
				2'd2:    grp = d.vlq[20:14];
				default: grp = d.vlq[27:21];
			endcase
			b = {(gi != 3'd0), grp};
		end else if (d.eot) begin
			case (ti)
				3'd0:    b = META_PREFIX;
				3'd1:    b = META_EOT;
				default: b = META_EOT_LEN;
			endcase
		end else if (d.send_status) begin
			case (ti)
				3'd0:    b = d.status;
				3'd1:    b = {1'b0, d.data_first};
				default: b = {1'b0, d.data_second};
			endcase
		end else begin
			case (ti)
				3'd0:    b = {1'b0, d.data_first};
				default: b = {1'b0, d.data_second};
			endcase
		end
		return b;
	endfunction

	logic [2:0]  idx_q;
	logic [31:0] count_q;
	logic [2:0]  tail_len;
	logic [2:0]  total_len;
	logic        load;
	logic        is_last;

	always_comb begin
		if (head.eot) begin
			tail_len = 3'd3;
		end else begin
			tail_len = 3'd1 + {2'b0, head.send_status} + {2'b0, head.two_data};
		end
	end

	assign total_len = head.vlq_len + tail_len;
	assign load      = head_valid && (!rsp_valid || rsp_ready);
	assign is_last   = (idx_q == total_len - 3'd1);
	assign pop       = load && is_last;

	always_ff @(posedge clk) begin
		if (load) begin
			rsp.out_byte    <= byte_at(head, idx_q);
			rsp.last        <= is_last;
			rsp.track_bytes <= (is_last && head.eot) ? count_q + 32'd1 : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
			idx_q     <= '0;
			count_q   <= '0;
		end else begin
			if (load) begin
				rsp_valid <= 1'b1;
				idx_q     <= is_last ? 3'd0 : idx_q + 3'd1;
				count_q   <= (is_last && head.eot) ? 32'd0 : count_q + 32'd1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/midi_track_event_serializer_unit.sv =====
// Top level of the MIDI track event serializer.
//
//   port group | dir | beat content
//   -----------+-----+---------------------------------------------------
//   req        | in  | one channel event or end-of-track request (req_t)
//   rsp        | out | one track byte, last flag, track byte count (rsp_t)
//
// An item that is not rejected yields two to seven bytes (delta bytes plus
// status and data, or plus FF 2F 00), one per cycle unless rsp stalls, and
// holds the serializer until its last byte. A QUEUE_DEPTH-entry queue takes
// one request per cycle while not full; rejected kinds make no byte.
// rsp is a registered output; a stall on rsp backs up the queue and then req.
// Reset clears the last tick, running status, byte count and queue.
`default_nettype none
module midi_track_event_serializer_unit #(
	parameter int unsigned QUEUE_DEPTH = mtes_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire mtes_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output mtes_pkg::rsp_t      rsp
);
	import mtes_pkg::*;

	localparam int unsigned DESC_W = $bits(desc_t);

	logic              queue_ready;
	logic              push;
	desc_t             push_desc;
	logic              pop;
	logic              head_valid;
	logic [DESC_W-1:0] head_bits;
	desc_t             head;

	assign head = desc_t'(head_bits);

	mtes_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.queue_ready (queue_ready),
		.push        (push),
		.desc        (push_desc)
	);

	mtes_queue #(
		.WIDTH (DESC_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_desc),
		.not_full  (queue_ready),
		.pop       (pop),
		.not_empty (head_valid),
		.head_data (head_bits)
	);

	mtes_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

endmodule
`default_nettype wire

// ===== test/mtes_track_checker.sv =====
// Checker: predicts the track byte stream from request beats and compares response beats.
module mtes_track_checker (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	input  wire logic           req_ready,
	input  wire mtes_pkg::req_t req,
	input  wire logic           rsp_valid,
	input  wire logic           rsp_ready,
	input  wire mtes_pkg::rsp_t rsp,
	output int                  errors,
	output int                  bytes_due
);
	timeunit 1ns;
	timeprecision 1ps;
	import mtes_pkg::*;

	logic [31:0] last_tick;
	logic [7:0]  live_status;
	logic [31:0] track_len;
	rsp_t        track_byte_queue[$];

	initial begin
		errors = 0;
		bytes_due = 0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		$display("%0t ns: %s mismatch, got %0h, want %0h", $time, what, got, want);
	endtask

	function automatic void encode_track_beat(input req_t r);
		logic [7:0]  out_seq[7];
		int          n;
		int          groups;
		logic [27:0] delta;
		logic [7:0]  status;
		logic        eot;
		rsp_t        b;
		n = 0;
		eot = (r.req_type == REQ_END_OF_TRACK);
		if (eot) begin
			delta = r.end_delta;
		end else if (r.message_kind < KIND_LOWEST_VALID || r.message_kind == KIND_SYSTEM) begin
			return;
		end else begin
			delta = 28'(r.event_tick - last_tick);
		end
		groups = 1;
		while (groups < 4 && (delta >> (7 * groups)) != 0)
			groups++;
		for (int i = groups - 1; i >= 0; i--) begin
			out_seq[n] = {(i > 0) ? 1'b1 : 1'b0, delta[7 * i +: 7]};
			n++;
		end
		if (eot) begin
			out_seq[n] = META_PREFIX;
			out_seq[n + 1] = META_EOT;
			out_seq[n + 2] = META_EOT_LEN;
			n += 3;
		end else begin
			status = {r.message_kind, (r.channel == 5'd0) ? 4'h0 : 4'(r.channel - 5'd1)};
			if (status != live_status) begin
				out_seq[n] = status;
				n++;
			end
			live_status = status;
			out_seq[n] = {1'b0, r.data_first[6:0]};
			n++;
			if (r.message_kind != KIND_PROGRAM && r.message_kind != KIND_PRESSURE) begin
				out_seq[n] = {1'b0, r.data_second[6:0]};
				n++;
			end
			last_tick = r.event_tick;
		end
		track_len += 32'(n);
		for (int k = 0; k < n; k++) begin
			b.out_byte = out_seq[k];
			b.last = (k == n - 1);
			b.track_bytes = (k == n - 1 && eot) ? track_len : 32'd0;
			track_byte_queue.push_back(b);
		end
		if (eot) begin
			last_tick = '0;
			live_status = '0;
			track_len = '0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			last_tick = '0;
			live_status = '0;
			track_len = '0;
			track_byte_queue.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (track_byte_queue.size() == 0) begin
					report_mismatch("unexpected beat, out_byte", 32'(rsp.out_byte), 32'd0);
				end else begin
					want = track_byte_queue.pop_front();
					if (rsp.out_byte !== want.out_byte)
						report_mismatch("out_byte", 32'(rsp.out_byte), 32'(want.out_byte));
					if (rsp.last !== want.last)
						report_mismatch("last", 32'(rsp.last), 32'(want.last));
					if (rsp.track_bytes !== want.track_bytes)
						report_mismatch("track_bytes", rsp.track_bytes, want.track_bytes);
				end
			end
			if (req_valid && req_ready)
				encode_track_beat(req);
		end
		bytes_due = track_byte_queue.size();
	end

endmodule

// ===== test/tb_midi_track_event_serializer_unit.sv =====
// Testbench top: drives event and end-of-track beats with random idling and gives the verdict.
module tb_midi_track_event_serializer_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import mtes_pkg::*;

	localparam int EVENT_GOAL  = 270;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE      = 40;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_t        req       = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_t        rsp;
	int          errors;
	int          bytes_due;
	int          cycles    = 0;
	int          events_sent = 0;
	bit          calm      = 1'b0;
	logic [31:0] tick_now  = '0;

	midi_track_event_serializer_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	mtes_track_checker watch (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.errors    (errors),
		.bytes_due (bytes_due)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic int idle_length();
		int pick;
		if (calm)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] next_delta();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 32'($urandom_range(0, 127));
			4, 5:       return 32'($urandom_range(128, 16383));
			6:          return 32'($urandom_range(16384, 2097151));
			7:          return 32'($urandom_range(2097152, 268435455));
			8:          return 32'd0;
			default:    return $urandom;
		endcase
	endfunction

	initial begin
		wait (arst_n);
		forever begin
			int stall;
			stall = idle_length();
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
	end

	task automatic send_beat(input req_t item);
		int gap;
		gap = idle_length();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		@(negedge clk);
	endtask

	task automatic put_event(input logic [31:0] delta, input logic [3:0] kind,
			input logic [4:0] chan, input logic [7:0] d1, input logic [7:0] d2);
		req_t r;
		r.req_type = REQ_EVENT;
		r.event_tick = tick_now + delta;
		r.message_kind = kind;
		r.channel = chan;
		r.data_first = d1;
		r.data_second = d2;
		r.end_delta = 28'($urandom);
		if (kind >= KIND_LOWEST_VALID && kind != KIND_SYSTEM) begin
			tick_now = r.event_tick;
			events_sent++;
		end
		send_beat(r);
	endtask

	task automatic put_end(input logic [27:0] delta);
		req_t r;
		r.req_type = REQ_END_OF_TRACK;
		r.event_tick = $urandom;
		r.message_kind = 4'($urandom);
		r.channel = 5'($urandom);
		r.data_first = 8'($urandom);
		r.data_second = 8'($urandom);
		r.end_delta = delta;
		tick_now = '0;
		events_sent++;
		send_beat(r);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (bytes_due != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	initial begin
		logic [3:0] pal_kind[3];
		logic [4:0] pal_chan[3];
		logic [3:0] kind;
		logic [4:0] chan;
		int         track_events;
		int         pick;
		bit         drained_mid;
		drained_mid = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		calm = 1'b1;
		put_event(32'h0, 4'h9, 5'd1, 8'h3C, 8'h64);
		put_event(32'h7F, 4'h9, 5'd1, 8'h3C, 8'h00);
		put_event(32'h80, 4'h9, 5'd1, 8'h40, 8'h7F);
		calm = 1'b0;
		put_event(32'h3FFF, 4'h9, 5'd1, 8'h41, 8'h10);
		put_event(32'h4000, 4'h9, 5'd1, 8'h42, 8'h11);
		put_event(32'h1FFFFF, 4'h9, 5'd1, 8'h43, 8'h12);
		put_event(32'h200000, 4'h9, 5'd1, 8'h44, 8'h13);
		put_event(32'h0FFFFFFF, 4'h9, 5'd1, 8'h45, 8'h14);
		put_event(32'h1, 4'h8, 5'd0, 8'hFF, 8'h80);
		put_event(32'h2, 4'hA, 5'd16, 8'h80, 8'hFF);
		put_event(32'h3, 4'hB, 5'd17, 8'h00, 8'h00);
		put_event(32'h4, KIND_PROGRAM, 5'd31, 8'h7F, 8'hAA);
		put_event(32'h5, KIND_PRESSURE, 5'd2, 8'h55, 8'h55);
		put_event(32'h6, 4'hE, 5'd5, 8'h7F, 8'h00);
		put_event(32'h7, 4'h0, 5'd3, 8'h12, 8'h34);
		put_event(32'h8, 4'h7, 5'd3, 8'h12, 8'h34);
		put_event(32'h9, KIND_SYSTEM, 5'd3, 8'h12, 8'h34);
		tick_now = 32'hFFFFFFF0;
		put_event(32'hF, 4'h9, 5'd4, 8'h20, 8'h30);
		tick_now = 32'd5;
		put_event(32'h0, 4'h9, 5'd4, 8'h21, 8'h31);
		put_end(28'h0FFFFFFF);
		put_end(28'h0);
		put_event(32'h10, 4'h9, 5'd1, 8'h3C, 8'h64);
		put_end(28'h7F);
		drain();

		while (events_sent < EVENT_GOAL) begin
			calm = ($urandom_range(0, 3) == 0);
			for (int p = 0; p < 3; p++) begin
				pal_kind[p] = 4'($urandom_range(KIND_LOWEST_VALID, KIND_SYSTEM - 1));
				pal_chan[p] = 5'($urandom_range(0, 31));
			end
			track_events = $urandom_range(1, 12);
			for (int e = 0; e < track_events; e++) begin
				pick = $urandom_range(0, 19);
				if (pick == 0) begin
					pick = $urandom_range(0, 8);
					kind = (pick == 8) ? KIND_SYSTEM : 4'(pick);
				end else if (pick < 14) begin
					pick = $urandom_range(0, 2);
					kind = pal_kind[pick];
				end else begin
					kind = 4'($urandom_range(KIND_LOWEST_VALID, KIND_SYSTEM - 1));
				end
				chan = (pick < 3) ? pal_chan[pick] : 5'($urandom_range(0, 31));
				put_event(next_delta(), kind, chan, 8'($urandom), 8'($urandom));
			end
			if ($urandom_range(0, 9) != 0)
				put_end(28'(next_delta()));
			if (!drained_mid && events_sent >= EVENT_GOAL / 2) begin
				drain();
				drained_mid = 1'b1;
			end
		end
		put_end(28'($urandom));

		req_valid <= 1'b0;
		while (bytes_due != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/mtes_pkg.sv
hdl/mtes_queue.sv
hdl/mtes_front.sv
hdl/mtes_back.sv
hdl/midi_track_event_serializer_unit.sv
test/mtes_track_checker.sv
test/tb_midi_track_event_serializer_unit.sv
